FILE: hdl/prf_pkg.sv
package prf_pkg;

	localparam int RULE_COUNT = 16;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam int FLAG_DROP     = 0;
	localparam int FLAG_SRC_MAC  = 1;
	localparam int FLAG_DEST_MAC = 2;
	localparam int FLAG_SRC_IP   = 3;
	localparam int FLAG_DEST_IP  = 4;
	localparam int FLAG_IN       = 5;
	localparam int FLAG_OUT      = 6;

	localparam logic CMD_CLASSIFY = 1'b0;
	localparam logic CMD_WRITE    = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic        direction;
		logic [3:0]  rule_index;
		logic [6:0]  rule_flags;
		logic [47:0] src_mac;
		logic [47:0] dest_mac;
		logic [31:0] src_ip;
		logic [31:0] dest_ip;
		logic [7:0]  src_proto;
		logic [7:0]  dest_proto;
		logic [15:0] sport;
		logic [15:0] dport;
	} req_t;

	typedef struct packed {
		logic drop;
		logic write_done;
	} rsp_t;

	typedef struct packed {
		logic [47:0] src_mac;
		logic [47:0] dest_mac;
		logic [31:0] src_ip;
		logic [31:0] dest_ip;
		logic [7:0]  src_proto;
		logic [7:0]  dest_proto;
		logic [15:0] sport;
		logic [15:0] dport;
	} rule_t;

	typedef struct packed {
		logic        l4;
		logic        direction;
		logic [47:0] src_mac;
		logic [47:0] dest_mac;
		logic [31:0] src_ip;
		logic [31:0] dest_ip;
		logic [7:0]  proto;
		logic [15:0] sport;
		logic [15:0] dport;
	} pkt_t;

	typedef struct packed {
		logic valid;
		logic drop;
		pkt_t pkt;
	} chain_t;

	function automatic logic port_ok(input logic [7:0] rproto, input logic [15:0] rport,
			input logic [7:0] pproto, input logic [15:0] pport);
		logic ok;
		if (rproto == pproto) begin
			ok = (rport == pport);
		end else begin
			ok = (rproto == 8'd0);
		end
		return ok;
	endfunction

endpackage

FILE: hdl/packet_rule_filter_core.sv
// Channel   Handshake              Payload           Direction
// command   start / busy           req (req_t)       in
// result    done (1-cycle strobe)  rsp (rsp_t)       out
//
// A rule write's result strobes in the cycle after acceptance.
// A packet walks the chain of RULE_COUNT rule cells, one cell per cycle, and its
// result is registered after the last cell; busy stays high until its result strobes.
// Reset clears all rule flags, so no rule is valid after reset.
// The receiver cannot stall; each result is shown for exactly one cycle.
module packet_rule_filter_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  prf_pkg::req_t  req,
	output logic           done,
	output prf_pkg::rsp_t  rsp
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t          state_q;
	logic            done_q;
	prf_pkg::rsp_t   rsp_q;
	logic            accept;
	logic            acc_wr;
	prf_pkg::rule_t  wr_rule;
	prf_pkg::chain_t link [prf_pkg::RULE_COUNT+1];
	logic            l4;

	assign busy   = (state_q == ST_WALK);
	assign accept = start && !busy;
	assign acc_wr = accept && (req.cmd == prf_pkg::CMD_WRITE);

	always_comb begin
		l4 = req.src_proto inside {prf_pkg::PROTO_TCP, prf_pkg::PROTO_UDP};
		wr_rule.src_mac    = req.src_mac;
		wr_rule.dest_mac   = req.dest_mac;
		wr_rule.src_ip     = req.src_ip;
		wr_rule.dest_ip    = req.dest_ip;
		wr_rule.src_proto  = req.src_proto;
		wr_rule.dest_proto = req.dest_proto;
		wr_rule.sport      = req.sport;
		wr_rule.dport      = req.dport;
		link[0].valid          = accept && (req.cmd == prf_pkg::CMD_CLASSIFY);
		link[0].drop           = 1'b0;
		link[0].pkt.l4         = l4;
		link[0].pkt.direction  = req.direction;
		link[0].pkt.src_mac    = req.src_mac;
		link[0].pkt.dest_mac   = req.dest_mac;
		link[0].pkt.src_ip     = req.src_ip;
		link[0].pkt.dest_ip    = req.dest_ip;
		link[0].pkt.proto      = req.src_proto;
		link[0].pkt.sport      = req.sport;
		link[0].pkt.dport      = req.dport;
	end

	for (genvar i = 0; i < prf_pkg::RULE_COUNT; i++) begin : g_cell
		logic we;
		assign we = acc_wr && (32'(req.rule_index) == i);
		prf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.we       (we),
			.wr_flags (req.rule_flags),
			.wr_rule  (wr_rule),
			.up       (link[i]),
			.down     (link[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (req.cmd == prf_pkg::CMD_WRITE) begin
							done_q           <= 1'b1;
							rsp_q.drop       <= 1'b0;
							rsp_q.write_done <= 1'b1;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (link[prf_pkg::RULE_COUNT].valid) begin
						done_q           <= 1'b1;
						rsp_q.drop       <= link[prf_pkg::RULE_COUNT].drop;
						rsp_q.write_done <= 1'b0;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: hdl/prf_cell.sv
module prf_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            we,
	input  logic [6:0]      wr_flags,
	input  prf_pkg::rule_t  wr_rule,
	input  prf_pkg::chain_t up,
	output prf_pkg::chain_t down
);

	logic [6:0]     flags_q;
	prf_pkg::rule_t rule_q;
	logic           valid_q;
	logic           drop_q;
	prf_pkg::pkt_t  pkt_q;
	logic           dir_ok;
	logic           hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (we) begin
			flags_q <= wr_flags;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			rule_q <= wr_rule;
		end
	end

	always_comb begin
		dir_ok = up.pkt.direction ? flags_q[prf_pkg::FLAG_OUT] : flags_q[prf_pkg::FLAG_IN];
		hit = up.pkt.l4 && dir_ok && flags_q[prf_pkg::FLAG_DROP]
			&& (!flags_q[prf_pkg::FLAG_SRC_MAC]  || rule_q.src_mac  == up.pkt.src_mac)
			&& (!flags_q[prf_pkg::FLAG_DEST_MAC] || rule_q.dest_mac == up.pkt.dest_mac)
			&& (!flags_q[prf_pkg::FLAG_SRC_IP]   || rule_q.src_ip   == up.pkt.src_ip)
			&& (!flags_q[prf_pkg::FLAG_DEST_IP]  || rule_q.dest_ip  == up.pkt.dest_ip)
			&& prf_pkg::port_ok(rule_q.src_proto, rule_q.sport,
				up.pkt.proto, up.pkt.sport)
			&& prf_pkg::port_ok(rule_q.dest_proto, rule_q.dport,
				up.pkt.proto, up.pkt.dport);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= up.valid;
		end
	end

	// advance packet and running drop to the next cell
	always_ff @(posedge clk) begin
		pkt_q  <= up.pkt;
		drop_q <= up.drop | hit;
	end

	assign down.valid = valid_q;
	assign down.drop  = drop_q;
	assign down.pkt   = pkt_q;

endmodule

FILE: hdl/prf_checker.sv
module prf_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input prf_pkg::req_t req,
	input logic          done,
	input prf_pkg::rsp_t rsp
);

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.cmd == prf_pkg::CMD_WRITE |=> done && rsp.write_done && !rsp.drop)
		else $error("rule write did not report in the next cycle");

	a_packet_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.cmd == prf_pkg::CMD_CLASSIFY |=> busy && !done)
		else $error("packet item did not raise busy");

	a_packet_end: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.write_done |-> !busy && $past(busy))
		else $error("packet result outside a busy period");

	a_drop_only_packet: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.drop && rsp.write_done))
		else $error("rule write reported a drop");

endmodule

bind packet_rule_filter_core prf_checker u_prf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);

FILE: test/packet_rule_filter_core_tb.sv
`timescale 1ns / 1ps

module packet_rule_filter_core_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1520;
	localparam int DRAIN_CYCLES = prf_pkg::RULE_COUNT + 8;
	localparam int REPORT_MAX   = 10;

	localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] IP_ONES  = 32'hFFFF_FFFF;
	localparam logic [7:0]  PROTO_ICMP = 8'd1;
	localparam logic [7:0]  PROTO_MAX  = 8'hFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	prf_pkg::req_t req = '0;
	logic done;
	prf_pkg::rsp_t rsp;

	logic [6:0] flag_mem [prf_pkg::RULE_COUNT];
	prf_pkg::rule_t rule_mem [prf_pkg::RULE_COUNT];
	prf_pkg::rsp_t verdict_q [$];
	int mismatches = 0;
	int cycles = 0;
	int writes_sent = 0;
	int packets_sent = 0;
	int drops_seen = 0;
	bit steady = 1'b0;

	packet_rule_filter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts pending", cycles, verdict_q.size());
			$display("tb: failure");
			$finish;
		end
	end

	function automatic bit rule_hits(int i, prf_pkg::req_t p);
		logic [6:0] f;
		prf_pkg::rule_t r;
		f = flag_mem[i];
		r = rule_mem[i];
		if (f[prf_pkg::FLAG_SRC_MAC] && r.src_mac != p.src_mac) return 1'b0;
		if (f[prf_pkg::FLAG_DEST_MAC] && r.dest_mac != p.dest_mac) return 1'b0;
		if (f[prf_pkg::FLAG_SRC_IP] && r.src_ip != p.src_ip) return 1'b0;
		if (f[prf_pkg::FLAG_DEST_IP] && r.dest_ip != p.dest_ip) return 1'b0;
		if (r.src_proto != 8'd0 && !(r.src_proto == p.src_proto && r.sport == p.sport))
			return 1'b0;
		if (r.dest_proto != 8'd0 && !(r.dest_proto == p.src_proto && r.dport == p.dport))
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic prf_pkg::rsp_t apply_item(prf_pkg::req_t it);
		prf_pkg::rsp_t v;
		int dir_flag;
		v = '0;
		dir_flag = it.direction ? prf_pkg::FLAG_OUT : prf_pkg::FLAG_IN;
		if (it.cmd == prf_pkg::CMD_WRITE) begin
			flag_mem[it.rule_index] = it.rule_flags;
			rule_mem[it.rule_index].src_mac = it.src_mac;
			rule_mem[it.rule_index].dest_mac = it.dest_mac;
			rule_mem[it.rule_index].src_ip = it.src_ip;
			rule_mem[it.rule_index].dest_ip = it.dest_ip;
			rule_mem[it.rule_index].src_proto = it.src_proto;
			rule_mem[it.rule_index].dest_proto = it.dest_proto;
			rule_mem[it.rule_index].sport = it.sport;
			rule_mem[it.rule_index].dport = it.dport;
			v.write_done = 1'b1;
		end else if (it.src_proto == prf_pkg::PROTO_TCP || it.src_proto == prf_pkg::PROTO_UDP)
				begin
			for (int i = 0; i < prf_pkg::RULE_COUNT; i++) begin
				if (flag_mem[i][dir_flag] && flag_mem[i][prf_pkg::FLAG_DROP] && rule_hits(i, it))
					v.drop = 1'b1;
			end
		end
		return v;
	endfunction

	function automatic int next_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(prf_pkg::req_t it);
		int gap;
		prf_pkg::rsp_t v;
		gap = next_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req <= it;
		do @(posedge clk); while (busy);
		@(negedge clk);
		v = apply_item(it);
		verdict_q.push_back(v);
		if (it.cmd == prf_pkg::CMD_WRITE) writes_sent++;
		else packets_sent++;
	endtask

	task automatic note_mismatch(string field, logic want, logic got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch in %s at cycle %0d: expected %0b, got %0b", field, cycles, want, got);
	endtask

	always @(posedge clk) begin
		prf_pkg::rsp_t want;
		if (arst_n && done) begin
			if (rsp.drop) drops_seen++;
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result at cycle %0d: drop=%0b write_done=%0b",
						cycles, rsp.drop, rsp.write_done);
			end else begin
				want = verdict_q.pop_front();
				if (rsp.drop !== want.drop) note_mismatch("drop", want.drop, rsp.drop);
				if (rsp.write_done !== want.write_done)
					note_mismatch("write_done", want.write_done, rsp.write_done);
			end
		end
	end

	function automatic prf_pkg::req_t rule_item(logic [3:0] idx, logic [6:0] flags,
			prf_pkg::rule_t r);
		prf_pkg::req_t it;
		it = '0;
		it.cmd = prf_pkg::CMD_WRITE;
		it.direction = 1'($urandom_range(0, 1));
		it.rule_index = idx;
		it.rule_flags = flags;
		it.src_mac = r.src_mac;
		it.dest_mac = r.dest_mac;
		it.src_ip = r.src_ip;
		it.dest_ip = r.dest_ip;
		it.src_proto = r.src_proto;
		it.dest_proto = r.dest_proto;
		it.sport = r.sport;
		it.dport = r.dport;
		return it;
	endfunction

	function automatic prf_pkg::req_t packet_item(logic dir, logic [7:0] proto,
			prf_pkg::rule_t r);
		prf_pkg::req_t it;
		it = rule_item(4'd0, 7'd0, r);
		it.cmd = prf_pkg::CMD_CLASSIFY;
		it.direction = dir;
		it.rule_index = 4'($urandom_range(0, 15));
		it.rule_flags = 7'($urandom_range(0, 127));
		it.src_proto = proto;
		it.dest_proto = 8'($urandom_range(0, 255));
		return it;
	endfunction

	function automatic logic [47:0] pick_mac();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		case ($urandom_range(0, 5))
			0: return '0;
			1: return MAC_ONES;
			default: return w[47:0];
		endcase
	endfunction

	function automatic logic [31:0] pick_ip();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return IP_ONES;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [15:0] pick_port();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 16'hFFFF;
			2: return 16'd80;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [7:0] pick_proto();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return prf_pkg::PROTO_TCP;
			4, 5, 6: return prf_pkg::PROTO_UDP;
			7: return 8'd0;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic prf_pkg::req_t random_item();
		prf_pkg::req_t it;
		logic [63:0] w;
		it.cmd = 1'($urandom_range(0, 1));
		it.direction = 1'($urandom_range(0, 1));
		it.rule_index = 4'($urandom_range(0, 15));
		it.rule_flags = 7'($urandom_range(0, 127));
		w = {$urandom(), $urandom()};
		it.src_mac = w[47:0];
		w = {$urandom(), $urandom()};
		it.dest_mac = w[47:0];
		it.src_ip = $urandom();
		it.dest_ip = $urandom();
		it.src_proto = 8'($urandom_range(0, 255));
		it.dest_proto = 8'($urandom_range(0, 255));
		it.sport = 16'($urandom_range(0, 65535));
		it.dport = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	function automatic prf_pkg::req_t random_rule();
		prf_pkg::rule_t r;
		logic [6:0] flags;
		r.src_mac = pick_mac();
		r.dest_mac = pick_mac();
		r.src_ip = pick_ip();
		r.dest_ip = pick_ip();
		r.src_proto = ($urandom_range(0, 1) == 0) ? 8'd0 : pick_proto();
		r.dest_proto = ($urandom_range(0, 1) == 0) ? 8'd0 : pick_proto();
		r.sport = pick_port();
		r.dport = pick_port();
		flags = 7'($urandom_range(0, 127));
		if ($urandom_range(0, 2) != 0) flags[prf_pkg::FLAG_DROP] = 1'b1;
		return rule_item(4'($urandom_range(0, 15)), flags, r);
	endfunction

	function automatic prf_pkg::req_t random_packet();
		prf_pkg::req_t it;
		prf_pkg::rule_t r;
		logic [6:0] f;
		int k;
		it = random_item();
		it.cmd = prf_pkg::CMD_CLASSIFY;
		it.src_proto = pick_proto();
		if ($urandom_range(0, 9) < 7) begin
			k = $urandom_range(0, prf_pkg::RULE_COUNT - 1);
			r = rule_mem[k];
			f = flag_mem[k];
			it.src_mac = r.src_mac;
			it.dest_mac = r.dest_mac;
			it.src_ip = r.src_ip;
			it.dest_ip = r.dest_ip;
			it.sport = r.sport;
			it.dport = r.dport;
			if (r.src_proto == prf_pkg::PROTO_TCP || r.src_proto == prf_pkg::PROTO_UDP)
				it.src_proto = r.src_proto;
			else if (r.dest_proto == prf_pkg::PROTO_TCP || r.dest_proto == prf_pkg::PROTO_UDP)
				it.src_proto = r.dest_proto;
			if (f[prf_pkg::FLAG_IN] != f[prf_pkg::FLAG_OUT]) it.direction = f[prf_pkg::FLAG_OUT];
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 6))
					0: it.src_mac[$urandom_range(0, 47)] ^= 1'b1;
					1: it.dest_mac[$urandom_range(0, 47)] ^= 1'b1;
					2: it.src_ip[$urandom_range(0, 31)] ^= 1'b1;
					3: it.dest_ip[$urandom_range(0, 31)] ^= 1'b1;
					4: it.sport[$urandom_range(0, 15)] ^= 1'b1;
					5: it.dport[$urandom_range(0, 15)] ^= 1'b1;
					default: it.direction = ~it.direction;
				endcase
			end
		end
		return it;
	endfunction

	task automatic test_empty_table();
		prf_pkg::rule_t ones;
		ones = '1;
		send_item(packet_item(1'b0, prf_pkg::PROTO_TCP, ones));
		send_item(packet_item(1'b1, prf_pkg::PROTO_UDP, ones));
		send_item(packet_item(1'b0, prf_pkg::PROTO_UDP, '0));
		send_item(packet_item(1'b1, prf_pkg::PROTO_TCP, '0));
	endtask

	task automatic test_field_compares();
		prf_pkg::rule_t r;
		prf_pkg::rule_t p;
		r = '{MAC_ONES, MAC_ONES, IP_ONES, IP_ONES, prf_pkg::PROTO_TCP, prf_pkg::PROTO_TCP,
			16'hFFFF, 16'h0000};
		send_item(rule_item(4'd0, 7'b0111111, r));
		send_item(packet_item(1'b0, prf_pkg::PROTO_TCP, r));
		send_item(packet_item(1'b0, prf_pkg::PROTO_UDP, r));
		send_item(packet_item(1'b0, PROTO_ICMP, r));
		send_item(packet_item(1'b0, PROTO_MAX, r));
		p = r;
		p.src_mac[0] = 1'b0;
		send_item(packet_item(1'b0, prf_pkg::PROTO_TCP, p));
		p = r;
		p.dest_ip[31] = 1'b0;
		send_item(packet_item(1'b0, prf_pkg::PROTO_TCP, p));
		p = r;
		p.dport = 16'h0001;
		send_item(packet_item(1'b0, prf_pkg::PROTO_TCP, p));
		r = '{48'h0, 48'h0, 32'h0, 32'h0, prf_pkg::PROTO_UDP, prf_pkg::PROTO_UDP, 16'h0, 16'h0};
		send_item(rule_item(4'd7, 7'b1111111, r));
		send_item(packet_item(1'b1, prf_pkg::PROTO_UDP, r));
		send_item(packet_item(1'b0, prf_pkg::PROTO_UDP, r));
	endtask

	task automatic test_direction_and_allow();
		prf_pkg::rule_t r;
		r = '{pick_mac(), pick_mac(), pick_ip(), pick_ip(), 8'd0, 8'd0, 16'h1234, 16'h4321};
		send_item(rule_item(4'd15, 7'b1100000, r));
		send_item(packet_item(1'b0, prf_pkg::PROTO_TCP, r));
		send_item(rule_item(4'd15, 7'b1100001, r));
		send_item(packet_item(1'b0, prf_pkg::PROTO_TCP, '1));
		send_item(packet_item(1'b1, prf_pkg::PROTO_UDP, '0));
		send_item(packet_item(1'b1, PROTO_ICMP, '0));
		send_item(rule_item(4'd15, 7'b0011111, r));
		send_item(packet_item(1'b1, prf_pkg::PROTO_UDP, '0));
		send_item(rule_item(4'd0, 7'b0000000, '0));
		send_item(rule_item(4'd7, 7'b0000000, '1));
		send_item(packet_item(1'b1, prf_pkg::PROTO_UDP, '0));
	endtask

	task automatic test_random_traffic();
		prf_pkg::req_t it;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: it = random_rule();
				5: it = random_item();
				default: it = random_packet();
			endcase
			send_item(it);
		end
		steady = 1'b0;
	endtask

	task automatic finish_run();
		start <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += verdict_q.size();
		$display("ran %0d rule writes and %0d packets, %0d packets dropped", writes_sent,
			packets_sent, drops_seen);
		$display("%0d mismatches over %0d cycles", mismatches, cycles);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	endtask

	initial begin
		for (int i = 0; i < prf_pkg::RULE_COUNT; i++) begin
			flag_mem[i] = '0;
			rule_mem[i] = '0;
		end
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_field_compares();
		test_direction_and_allow();
		test_random_traffic();
		finish_run();
	end

endmodule
